// ----- rtl/core/xcpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR-checked packet deframer package
// Shared types and constants for the frame parser, result stage and
// configuration register.
// ----------------------------------------------------------------------------
package xcpd_pkg;

    localparam logic [7:0] START_BYTE    = 8'hAA;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd6;
    localparam logic [7:0] CAPACITY_RST  = 8'd249;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEN   = 2'd1,
        ST_BAD_SUM   = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [15:0] command;
        logic [7:0]  length;
        logic        frame_end;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/xor_checked_packet_deframer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR-checked packet deframer
// Parses length-prefixed serial frames and reports payload bytes and status.
// ----------------------------------------------------------------------------
// The block can take one received byte in every cycle and answers each byte
// with at most one result in the next cycle: a payload byte as it arrives, or
// one status result at the end of a frame (or at once for a bad length).
// The rate is set by the single frame-state register update per byte; the
// result register lets a new byte in while a held result is being taken.
// While a result waits in the result register and the consumer is not ready,
// no byte is taken, even one that would give no result.
// Payload of a frame whose status is not ok must be dropped by the consumer.
module xor_checked_packet_deframer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic             o_out_kind,
    output logic      [7:0]  o_payload_byte,
    output logic      [1:0]  o_frame_status,
    output logic      [15:0] o_frame_command,
    output logic      [7:0]  o_payload_length,
    output logic             o_frame_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import xcpd_pkg::*;

    logic       w_accept;
    logic       w_free;
    logic       w_load;
    logic [7:0] w_capacity;
    t_result    w_res;
    t_result    w_out;

    assign o_rx_ready = w_free;
    assign w_accept   = i_rx_valid && w_free;

    xcpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    xcpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_capacity  (w_capacity),
        .o_res_valid (w_load),
        .o_res       (w_res)
    );

    xcpd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .i_ready (i_res_ready),
        .o_free  (w_free),
        .o_valid (o_res_valid),
        .o_res   (w_out)
    );

    assign o_out_kind       = w_out.kind;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_frame_status   = w_out.status;
    assign o_frame_command  = w_out.command;
    assign o_payload_length = w_out.length;
    assign o_frame_end      = w_out.frame_end;

endmodule
`default_nettype wire

// ----- rtl/core/xcpd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration register
// APB-style port holding the response capacity register.
// ----------------------------------------------------------------------------
module xcpd_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  o_capacity
);
    import xcpd_pkg::*;

    logic [7:0] r_capacity;
    logic       w_hit;

    assign w_hit = (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
        end else if (psel && penable && pwrite && w_hit) begin
            r_capacity <= pwdata[7:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = w_hit ? {24'd0, r_capacity} : 32'd0;
    assign o_capacity = r_capacity;

endmodule
`default_nettype wire

// ----- rtl/core/xcpd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame position and checksum, and forms at most one result for
// each accepted byte.
// ----------------------------------------------------------------------------
module xcpd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [7:0]       i_capacity,
    output logic                  o_res_valid,
    output xcpd_pkg::t_result     o_res
);
    import xcpd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  w_plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 8'd0;
            r_pos   <= 8'd0;
            r_xor   <= 8'd0;
            r_cmd   <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
        end
    end

    assign w_plen = r_len - MIN_FRAME_LEN;

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_cmd       = r_cmd;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_LEN: begin
                    n_xor = i_rx_byte;
                    if (i_rx_byte < MIN_FRAME_LEN) begin
                        n_phase         = PH_HUNT;
                        n_pos           = 8'd0;
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_STATUS;
                        o_res.status    = ST_BAD_LEN;
                        o_res.frame_end = 1'b1;
                    end else begin
                        n_len   = i_rx_byte;
                        n_pos   = 8'd2;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_pos == r_len - 8'd1) begin
                        n_phase         = PH_HUNT;
                        n_pos           = 8'd0;
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_STATUS;
                        o_res.command   = r_cmd;
                        o_res.length    = w_plen;
                        o_res.frame_end = 1'b1;
                        if (r_xor != 8'd0) begin
                            o_res.status = ST_BAD_SUM;
                        end else if (w_plen > i_capacity) begin
                            o_res.status = ST_TOO_LARGE;
                        end else begin
                            o_res.status = ST_OK;
                        end
                    end else begin
                        n_xor = r_xor ^ i_rx_byte;
                        n_pos = r_pos + 8'd1;
                        if (r_pos == 8'd2) begin
                            n_cmd = {i_rx_byte, r_cmd[7:0]};
                        end else if (r_pos == 8'd3) begin
                            n_cmd = {r_cmd[15:8], i_rx_byte};
                        end else if (({1'b0, r_pos} + 9'd2) < {1'b0, r_len}) begin
                            o_res_valid        = 1'b1;
                            o_res.kind         = KIND_PAYLOAD;
                            o_res.payload_byte = i_rx_byte;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_rx_byte == START_BYTE) begin
                        n_phase = PH_LEN;
                        n_pos   = 8'd1;
                        n_xor   = 8'd0;
                        n_cmd   = 16'd0;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/xcpd_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the consumer completes the transfer, and allows a
// new result to be loaded in the cycle the held one leaves.
// ----------------------------------------------------------------------------
module xcpd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire xcpd_pkg::t_result i_res,
    input  wire logic             i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output xcpd_pkg::t_result     o_res
);
    import xcpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire
